/* rtl/core/spd_pkg.sv */
// Shared types, constants and helpers for the servo pulse decoder.
package spd_pkg;

    localparam int WIDTH_BITS = 16;
    localparam int FRAC_BITS  = 15;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

    localparam logic signed [WIDTH_BITS-1:0] POS_MAX  = WIDTH_BITS'((1 << FRAC_BITS) - 1);
    localparam logic signed [WIDTH_BITS-1:0] POS_HALF = WIDTH_BITS'(1 << (FRAC_BITS - 1));

    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_END    = 2'd1;
    localparam logic [1:0] CFG_MEDIAN = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                  done;
        logic                  rnd;
        logic [WIDTH_BITS-1:0] quo;
    } t_div_res;

    function automatic logic signed [WIDTH_BITS-1:0] med3(
        input logic signed [WIDTH_BITS-1:0] a,
        input logic signed [WIDTH_BITS-1:0] b,
        input logic signed [WIDTH_BITS-1:0] c
    );
        logic signed [WIDTH_BITS-1:0] lo_ab;
        logic signed [WIDTH_BITS-1:0] hi_ab;
        logic signed [WIDTH_BITS-1:0] lo_hc;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a > b) ? a : b;
        lo_hc = (hi_ab < c) ? hi_ab : c;
        return (lo_ab > lo_hc) ? lo_ab : lo_hc;
    endfunction

endpackage

/* rtl/core/spd_div.sv */
// Restoring serial divider: quotient of (mag << FRAC_BITS) / span plus round bit.
module spd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [spd_pkg::WIDTH_BITS-1:0] i_mag,
    input  logic [spd_pkg::WIDTH_BITS-1:0] i_span,
    output spd_pkg::t_div_res              o_res
);
    import spd_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_rnd,  n_rnd;
    logic [CNT_BITS-1:0]   r_cnt,  n_cnt;
    logic [WIDTH_BITS:0]   r_rem,  n_rem;
    logic [WIDTH_BITS-1:0] r_quo,  n_quo;
    logic [WIDTH_BITS-1:0] r_span, n_span;

    logic [WIDTH_BITS:0]   trial;
    logic [WIDTH_BITS:0]   diff;
    logic                  ge;

    always_comb begin
        // first step compares the bare remainder, later steps shift it
        trial = (r_cnt == CNT_BITS'(DIV_STEPS)) ? r_rem : {r_rem[WIDTH_BITS-1:0], 1'b0};
        ge    = trial >= {1'b0, r_span};
        diff  = trial - {1'b0, r_span};

        n_busy = r_busy;
        n_done = 1'b0;
        n_rnd  = r_rnd;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_span = r_span;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(DIV_STEPS);
            n_rem  = {1'b0, i_mag};
            n_quo  = '0;
            n_span = i_span;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                // last pass: 2r >= span decides rounding
                n_rnd  = ge;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_quo = {r_quo[WIDTH_BITS-2:0], ge};
                n_rem = ge ? diff : trial;
                n_cnt = r_cnt - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rnd  <= n_rnd;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_span <= n_span;
    end

    assign o_res.done = r_done;
    assign o_res.rnd  = r_rnd;
    assign o_res.quo  = r_quo;

endmodule

/* rtl/core/servo_pulse_decoder_unit.sv */
// Top level of the servo pulse decoder: window checks, sequencer and result register.
//
// Each input item is one measured pulse width in microseconds. The block takes one item
// at a time: after acceptance it runs the window checks (ST_CHECK), then the serial
// divider (ST_DIV: 16 quotient bits and one rounding compare, all on the same
// subtract-and-compare unit, with the done flag and quotient handed back through a
// register) and then updates the position (ST_FIN); only after that finishing step
// does the block return to idle and accept the next item. A rejected pulse skips the
// divider and goes from the window checks straight to the finishing step.
// The next item is accepted while the previous result still waits in the output register;
// the finishing step stalls only if that register is still full. Every input item yields
// exactly one result: tuser carries the accept flag, tdata the held Q1.15 position and
// the raw width echoed back. Configuration writes are always ready and should be made
// while the block is idle.
module servo_pulse_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] pulse_width_us
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] position, [31:16] last_width_us
    output logic        o_m_tuser,   // [0] accepted
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import spd_pkg::*;

    // configuration
    logic [WIDTH_BITS-1:0] r_start;
    logic [WIDTH_BITS-1:0] r_end;
    logic                  r_median;

    // sequencer
    t_state r_state, n_state;

    // item in flight
    logic [WIDTH_BITS-1:0]        r_width;
    logic                         r_ok;
    logic                         r_neg;
    logic signed [WIDTH_BITS-1:0] r_cand;

    // position state
    logic signed [WIDTH_BITS-1:0] r_held;
    logic signed [WIDTH_BITS-1:0] r_hist_new;
    logic signed [WIDTH_BITS-1:0] r_hist_old;

    // result register
    logic                  r_out_valid;
    logic                  r_out_acc;
    logic [WIDTH_BITS-1:0] r_out_pos;
    logic [WIDTH_BITS-1:0] r_out_width;

    // window checks
    logic                  span_ok;
    logic [WIDTH_BITS-1:0] span;
    logic [WIDTH_BITS-1:0] len;
    logic [WIDTH_BITS+2:0] len_x5;
    logic [WIDTH_BITS+2:0] span_x6;
    logic [WIDTH_BITS+2:0] w_x5;
    logic [WIDTH_BITS+2:0] s_x4;
    logic                  chk_ok;
    logic [WIDTH_BITS-1:0] len_eff;
    logic [WIDTH_BITS:0]   twice;
    logic                  chk_neg;
    logic [WIDTH_BITS:0]   mag_wide;

    // divider
    logic     div_start;
    t_div_res div_res;
    logic [WIDTH_BITS:0]          q_round;
    logic signed [WIDTH_BITS-1:0] cand;

    // finishing
    logic                         slot_free;
    logic                         fin_go;
    logic signed [WIDTH_BITS-1:0] new_pos;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign slot_free   = !r_out_valid || i_m_tready;

    always_comb begin
        span_ok = r_end > r_start;
        span    = r_end - r_start;
        len     = r_width - r_start;
        len_x5  = {1'b0, len, 2'b00} + {3'b000, len};
        span_x6 = {1'b0, span, 2'b00} + {2'b00, span, 1'b0};
        w_x5    = {1'b0, r_width, 2'b00} + {3'b000, r_width};
        s_x4    = {1'b0, r_start, 2'b00};

        chk_ok  = 1'b0;
        len_eff = '0;
        if (span_ok) begin
            if (r_width >= r_start) begin
                if (len <= span) begin
                    chk_ok  = 1'b1;
                    len_eff = len;
                end else if (len_x5 < span_x6) begin
                    // slightly long: clamp to full scale
                    chk_ok  = 1'b1;
                    len_eff = span;
                end
            end else if (w_x5 > s_x4) begin
                // slightly short: clamp to the window start (length zero)
                chk_ok = 1'b1;
            end
        end

        twice    = {len_eff, 1'b0};
        chk_neg  = twice < {1'b0, span};
        mag_wide = chk_neg ? ({1'b0, span} - twice) : (twice - {1'b0, span});
    end

    assign div_start = (r_state == ST_CHECK) && chk_ok;

    spd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag_wide[WIDTH_BITS-1:0]),
        .i_span  (span),
        .o_res   (div_res)
    );

    // round, negate, saturate at the positive end
    always_comb begin
        q_round = {1'b0, div_res.quo} + {{WIDTH_BITS{1'b0}}, div_res.rnd};
        if (r_neg) begin
            cand = -$signed(q_round[WIDTH_BITS-1:0]);
        end else if (q_round > {1'b0, POS_MAX}) begin
            cand = POS_MAX;
        end else begin
            cand = $signed(q_round[WIDTH_BITS-1:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        fin_go  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = chk_ok ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the result register can take the item
                if (slot_free) begin
                    fin_go  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign new_pos = r_median ? med3(r_cand, r_hist_new, r_hist_old) : r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 16'd1000;
            r_end       <= 16'd2000;
            r_median    <= 1'b0;
            r_held      <= '0;
            r_hist_new  <= POS_HALF;
            r_hist_old  <= POS_HALF;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_START:  r_start  <= i_cfg_data;
                    CFG_END:    r_end    <= i_cfg_data;
                    CFG_MEDIAN: r_median <= i_cfg_data[0];
                    default:    ;
                endcase
            end

            if (r_state == ST_CHECK) begin
                r_ok <= chk_ok;
            end

            if (fin_go) begin
                r_out_valid <= 1'b1;
                if (r_ok) begin
                    r_held <= new_pos;
                    if (r_median) begin
                        r_hist_old <= r_hist_new;
                        r_hist_new <= r_cand;
                    end
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload, no reset needed
        if (o_s_tready && i_s_tvalid) begin
            r_width <= i_s_tdata;
        end
        if (r_state == ST_CHECK) begin
            r_neg <= chk_neg;
        end
        if (r_state == ST_DIV && div_res.done) begin
            r_cand <= cand;
        end
        if (fin_go) begin
            r_out_acc   <= r_ok;
            r_out_pos   <= r_ok ? new_pos : r_held;
            r_out_width <= r_width;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_acc;
    assign o_m_tdata  = {r_out_width, r_out_pos};

endmodule
